// File: rtl/polyblep_oscillator_unit_assert.svh
// Assertion macros used by the oscillator top-level RTL file.
`ifndef POLYBLEP_OSCILLATOR_UNIT_ASSERT_SVH
`define POLYBLEP_OSCILLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define POU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define POU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/pbo_pkg.sv
// Shared types and constants of the PolyBLEP oscillator.
package pbo_pkg;

    typedef enum logic [1:0] {
        WAVE_SAW      = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SINE     = 2'd3
    } wave_t;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_WIDTH = 1'b1;

    // pi/2 in Q2.30 and the Taylor series divisors (2i)*(2i+1)
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    // Triangle leak factor 999/1000
    localparam int unsigned TRI_LEAK_NUM = 999;
    localparam int unsigned TRI_LEAK_DEN = 1000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/polyblep_oscillator_unit.sv
// Top level of the PolyBLEP oscillator: control sequencer and datapath.
// Sine is read from the table; saw, square and triangle may run PolyBLEP division
// passes on the shared divider with its NUM_W-bit numerator (NUM_W =
// PHASE_BITS+SAMPLE_BITS-3, 45 at default), triangle also a leak division. One item
// is in work at a time; the next transfer is taken as soon as the result sits in the output register.
// Reset (async, active low) clears phase and integrator, selects saw, sets pulse width to 1/2.
`include "polyblep_oscillator_unit_assert.svh"
module polyblep_oscillator_unit
    import pbo_pkg::*;
#(
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_INDEX_W-1:0]             cfg_index,
    input  logic [PHASE_BITS-1:0]              cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // phase_increment
    input  logic [((PHASE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sample_value
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int PB    = PHASE_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int FRAC  = SB - 4;
    localparam int SUM_W = SB + 2;
    localparam int OUT_W = ((SB + 7) / 8) * 8;
    localparam int NUM_W = (PB + FRAC + 1 > SB + 9) ? PB + FRAC + 1 : SB + 9;
    localparam int DEN_W = (PB > 10) ? PB : 10;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    localparam logic [PB-1:0]   HALF_PH = {1'b1, {(PB-1){1'b0}}};
    localparam logic [PB:0]     ONE_PH  = {1'b1, {PB{1'b0}}};
    localparam logic [FRAC:0]   ONE_F   = {1'b1, {FRAC{1'b0}}};
    localparam logic [PB-1:0]   PW_MIN  = PB'((64'd1 << PB) / 100);
    localparam logic [PB-1:0]   PW_MAX  = PB'(((64'd1 << PB) * 99) / 100);
    localparam logic signed [SUM_W-1:0] S_MAX_X = SUM_W'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [SUM_W-1:0] S_MIN_X = -S_MAX_X - 1;
    localparam logic signed [SUM_W-1:0] ONE_X   = SUM_W'(ONE_F);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_PREP    = 11'b00000000010,
        S_CHECK   = 11'b00000000100,
        S_DIV     = 11'b00000001000,
        S_SQR     = 11'b00000010000,
        S_SINE    = 11'b00000100000,
        S_TRI_MUL = 11'b00001000000,
        S_TRI_ADD = 11'b00010000000,
        S_TRI_SCL = 11'b00100000000,
        S_TRI_DIV = 11'b01000000000,
        S_FINISH  = 11'b10000000000
    } state_t;

    typedef logic signed [SB-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Build the quarter-folded Taylor sine table at elaboration
    function automatic sine_rom_t build_sine();
        sine_rom_t       rom;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        logic            neg;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            q   = (64'(4) * 64'(k)) / SINE_TABLE_DEPTH;
            r   = (64'(4) * 64'(k)) % SINE_TABLE_DEPTH;
            neg = (q >= 64'd2);
            if (q[0])
            begin
                r = 64'(SINE_TABLE_DEPTH) - r;
            end
            x    = (r * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            s    = x;
            for (int i = 1; i <= 7; i++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[i];
                if (i % 2 == 1)
                begin
                    s = (s > term) ? s - term : 64'd0;
                end
                else
                begin
                    s = s + term;
                end
            end
            s = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            if (s > 64'(ONE_F))
            begin
                s = 64'(ONE_F);
            end
            rom[k] = neg ? -SB'(s) : SB'(s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    // Clip a wide sum to the sample range
    function automatic logic signed [SB-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > S_MAX_X)
        begin
            c = S_MAX_X;
        end
        else if (v < S_MIN_X)
        begin
            c = S_MIN_X;
        end
        return c[SB-1:0];
    endfunction

    state_t                  state_reg;
    state_t                  state_next;
    wave_t                   wave_reg;
    logic [PB-1:0]           pw_reg;
    logic [PB-1:0]           acc_reg;
    logic signed [SB-1:0]    tri_reg;
    logic                    out_valid_reg;
    logic [SB-1:0]           out_data_reg;

    logic [PB-1:0]           dt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    bidx_reg;
    logic                    neg_reg;
    logic [FRAC:0]           d_reg;
    logic [SUM_W-1:0]        inc_reg;
    logic                    tneg_reg;
    logic [SB-1:0]           tm_reg;
    logic signed [SB-1:0]    rom_q_reg;

    logic [PB-1:0]           dt_in;
    logic [PB-1:0]           dt_clamp;
    logic [PB-1:0]           t_sel;
    logic [PB:0]             t_ext;
    logic                    blep_lo;
    logic                    blep_hi;
    logic                    blep_active;
    logic [PB:0]             blep_base;
    logic                    need_second;
    state_t                  after_blep;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic [NUM_W-1:0]        div_quot;
    div_status_t             div_stat;
    logic [FRAC:0]           d_calc;
    logic [2*FRAC+1:0]       sqr_prod;
    logic signed [SUM_W-1:0] sqr_val;
    logic [PB+FRAC:0]        saw_wide;
    logic signed [SUM_W-1:0] saw_base;
    logic signed [SUM_W-1:0] sq_base;
    logic [SUM_W-1:0]        sum_mag;
    logic [PB+SUM_W+1:0]     tri_prod;
    logic signed [SUM_W-1:0] tri_sum;
    logic signed [SB-1:0]    tri_sat;
    logic [NUM_W-1:0]        leak_num;
    logic [SB-1:0]           leak_q;
    logic signed [SB-1:0]    tri_new;
    logic [PB+IDX_W-1:0]     sine_prod;
    logic [IDX_W-1:0]        sine_idx;

    // Clamp the incoming increment to one half
    assign dt_in    = s_axis_tdata[PB-1:0];
    assign dt_clamp = (dt_in > HALF_PH) ? HALF_PH : dt_in;

    // Select the phase for this PolyBLEP pass and classify it
    assign t_sel       = bidx_reg ? acc_reg - pw_reg : acc_reg;
    assign t_ext       = {1'b0, t_sel};
    assign blep_lo     = t_sel < dt_reg;
    assign blep_hi     = (t_ext + {1'b0, dt_reg}) > ONE_PH;
    assign blep_active = (dt_reg != '0) && (blep_lo || blep_hi);
    assign blep_base   = blep_lo ? t_ext : ONE_PH - t_ext;
    assign need_second = ((wave_reg == WAVE_SQUARE) || (wave_reg == WAVE_TRIANGLE)) && !bidx_reg;
    assign after_blep  = need_second ? S_CHECK :
                         ((wave_reg == WAVE_TRIANGLE) ? S_TRI_MUL : S_FINISH);

    // Feed the shared divider
    assign div_start = ((state_reg == S_CHECK) && blep_active) || (state_reg == S_TRI_SCL);
    assign leak_num  = NUM_W'(tm_reg) * NUM_W'(TRI_LEAK_NUM);
    assign div_num   = (state_reg == S_TRI_SCL) ? leak_num
                                                : NUM_W'({blep_base, {FRAC{1'b0}}});
    assign div_den   = (state_reg == S_TRI_SCL) ? DEN_W'(TRI_LEAK_DEN) : DEN_W'(dt_reg);

    pbo_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_stat)
    );

    // Residual (1-n)^2
    assign d_calc   = (div_quot >= NUM_W'(ONE_F)) ? '0 : ONE_F - div_quot[FRAC:0];
    assign sqr_prod = (2*FRAC+2)'(d_reg) * (2*FRAC+2)'(d_reg);
    assign sqr_val  = $signed(SUM_W'(sqr_prod[2*FRAC+1:FRAC]));

    // Naive waveforms
    assign saw_wide = {acc_reg, {(FRAC+1){1'b0}}};
    assign saw_base = $signed(SUM_W'(saw_wide[PB+FRAC:PB])) - ONE_X;
    assign sq_base  = (acc_reg < pw_reg) ? ONE_X : -ONE_X;

    // Triangle integrator step and leak
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign tri_prod = (PB+SUM_W+2)'({dt_reg, 2'b00}) * (PB+SUM_W+2)'(sum_mag);
    assign tri_sum  = sum_reg[SUM_W-1] ? SUM_W'(tri_reg) - $signed(inc_reg)
                                       : SUM_W'(tri_reg) + $signed(inc_reg);
    assign tri_sat  = sat_sample(tri_sum);
    assign leak_q   = div_quot[SB-1:0];
    assign tri_new  = tneg_reg ? -$signed(leak_q) : $signed(leak_q);

    // Sine table index
    assign sine_prod = (PB+IDX_W)'(acc_reg) * (PB+IDX_W)'(SINE_TABLE_DEPTH);
    assign sine_idx  = sine_prod[PB+IDX_W-1:PB];

    // Sequence one item
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_axis_tvalid) state_next = S_PREP;
            S_PREP:    state_next = (wave_reg == WAVE_SINE) ? S_SINE : S_CHECK;
            S_CHECK:   state_next = blep_active ? S_DIV : after_blep;
            S_DIV:     if (div_stat.done) state_next = S_SQR;
            S_SQR:     state_next = after_blep;
            S_SINE:    state_next = S_FINISH;
            S_TRI_MUL: state_next = S_TRI_ADD;
            S_TRI_ADD: state_next = S_TRI_SCL;
            S_TRI_SCL: state_next = S_TRI_DIV;
            S_TRI_DIV: if (div_stat.done) state_next = S_FINISH;
            S_FINISH:  if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wave_reg      <= WAVE_SAW;
            pw_reg        <= HALF_PH;
            acc_reg       <= '0;
            tri_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WAVEFORM:    wave_reg <= wave_t'(cfg_data[1:0]);
                    CFG_PULSE_WIDTH: pw_reg   <= (cfg_data < PW_MIN) ? PW_MIN :
                                                 ((cfg_data > PW_MAX) ? PW_MAX : cfg_data);
                    default:         ;
                endcase
            end
            if ((state_reg == S_TRI_DIV) && div_stat.done && (wave_reg == WAVE_TRIANGLE))
            begin
                tri_reg <= tri_new;
            end
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_reg + dt_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        rom_q_reg <= SINE_ROM[sine_idx];
        unique case (state_reg)
            S_IDLE:
            begin
                dt_reg <= dt_clamp;
            end
            S_PREP:
            begin
                bidx_reg <= 1'b0;
                sum_reg  <= (wave_reg == WAVE_SAW) ? saw_base : sq_base;
            end
            S_CHECK:
            begin
                neg_reg <= blep_lo ^ ((wave_reg == WAVE_SAW) || bidx_reg);
                if (!blep_active && need_second)
                begin
                    bidx_reg <= 1'b1;
                end
            end
            S_DIV:
            begin
                d_reg <= d_calc;
            end
            S_SQR:
            begin
                sum_reg <= neg_reg ? sum_reg - sqr_val : sum_reg + sqr_val;
                if (need_second)
                begin
                    bidx_reg <= 1'b1;
                end
            end
            S_SINE:
            begin
                sum_reg <= SUM_W'(rom_q_reg);
            end
            S_TRI_MUL:
            begin
                inc_reg <= tri_prod[PB+SUM_W-1:PB];
            end
            S_TRI_ADD:
            begin
                tneg_reg <= tri_sat[SB-1];
                tm_reg   <= tri_sat[SB-1] ? SB'(-tri_sat) : SB'(tri_sat);
            end
            S_TRI_SCL:
            begin
                tneg_reg <= tneg_reg;
            end
            S_TRI_DIV:
            begin
                sum_reg <= SUM_W'(tri_new);
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= sat_sample(sum_reg);
                end
            end
            default:
            begin
                bidx_reg <= bidx_reg;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    `POU_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy)
    `POU_ASSERT_IMP(a_div_done_state, div_stat.done,
                    (state_reg == S_DIV) || (state_reg == S_TRI_DIV))
    `POU_ASSERT_NXT(a_phase_hold, state_reg != S_FINISH, $stable(acc_reg))
    `POU_ASSERT_NXT(a_tri_hold, wave_reg != WAVE_TRIANGLE, $stable(tri_reg))

endmodule

// File: rtl/pbo_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pbo_divider
    import pbo_pkg::*;
#(
    parameter int NUM_W = 45,
    parameter int DEN_W = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // Trial subtract of the divisor from the shifted remainder
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    // Sequence the passes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Shift numerator out and quotient bits in
    always_ff @(posedge clk) begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quot        = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: tb/sv/polyblep_oscillator_unit_chk.sv
// Checker of the PolyBLEP oscillator: mirrors registers and state, predicts and compares samples.
module polyblep_oscillator_unit_chk
    import pbo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          fail_count,
    output int          samples_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = 24;
    localparam int FB = 20;
    localparam int DEPTH = 1024;
    localparam longint unsigned UNITY = 64'd1 << FB;
    localparam longint unsigned PH_FULL = 64'd1 << PB;
    localparam longint unsigned PW_LO = PH_FULL / 100;
    localparam longint unsigned PW_HI = (PH_FULL * 99) / 100;
    localparam longint S_HI = 64'sd8388607;
    localparam longint S_LO = -64'sd8388608;

    int              sine_rom [DEPTH];
    wave_t           wave_sel;
    longint unsigned duty;
    longint unsigned phase;
    longint          tri_acc;
    logic [23:0]     sample_q [$];

    // Fill the sine table by quadrant folding and a Q2.30 Taylor series
    initial begin
        longint unsigned q, r, x, x2, term, s;
        for (int k = 0; k < DEPTH; k++) begin
            q = (4 * k) / DEPTH;
            r = (4 * k) % DEPTH;
            if (q[0])
                r = DEPTH - r;
            x = (r * HALF_PI_Q30) / DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            s = x;
            for (int i = 1; i <= 7; i++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[i];
                if (i % 2 == 1)
                    s = (s > term) ? s - term : 0;
                else
                    s = s + term;
            end
            s = (s + (64'd1 << (29 - FB))) >> (30 - FB);
            if (s > UNITY)
                s = UNITY;
            sine_rom[k] = (q >= 2) ? -int'(s) : int'(s);
        end
    end

    function automatic longint clip(longint v);
        if (v > S_HI)
            return S_HI;
        if (v < S_LO)
            return S_LO;
        return v;
    endfunction

    // Two-sample residual around a discontinuity at phase t
    function automatic longint blep_residual(longint unsigned t, longint unsigned dt);
        longint unsigned n, d;
        if (dt == 0)
            return 0;
        if (t < dt) begin
            n = (t << FB) / dt;
            d = UNITY - n;
            return -longint'((d * d) >> FB);
        end
        if (t + dt > PH_FULL) begin
            n = ((PH_FULL - t) << FB) / dt;
            d = (n < UNITY) ? UNITY - n : 0;
            return longint'((d * d) >> FB);
        end
        return 0;
    endfunction

    function automatic longint pulse_level(longint unsigned ph, longint unsigned dt);
        longint v;
        v = (ph < duty) ? longint'(UNITY) : -longint'(UNITY);
        v = v + blep_residual(ph, dt);
        v = v - blep_residual((ph + PH_FULL - duty) & (PH_FULL - 1), dt);
        return v;
    endfunction

    // Compute one sample and advance phase and integrator
    function automatic logic [23:0] next_sample(logic [23:0] incr);
        longint unsigned dt, mag, tm, idx;
        longint s, sq, step, t, lk;
        dt = incr;
        if (dt > PH_FULL / 2)
            dt = PH_FULL / 2;
        case (wave_sel)
            WAVE_SAW: begin
                s = longint'((phase << (FB + 1)) >> PB) - longint'(UNITY);
                s = s - blep_residual(phase, dt);
            end
            WAVE_SQUARE: s = pulse_level(phase, dt);
            WAVE_TRIANGLE: begin
                sq = pulse_level(phase, dt);
                mag = (sq < 0) ? -sq : sq;
                step = longint'((4 * dt * mag) >> PB);
                t = clip(tri_acc + ((sq < 0) ? -step : step));
                tm = (t < 0) ? -t : t;
                lk = longint'((tm * TRI_LEAK_NUM) / TRI_LEAK_DEN);
                tri_acc = (t < 0) ? -lk : lk;
                s = tri_acc;
            end
            default: begin
                idx = (phase * DEPTH) >> PB;
                if (idx >= DEPTH)
                    idx = DEPTH - 1;
                s = sine_rom[idx];
            end
        endcase
        phase = (phase + dt) & (PH_FULL - 1);
        return 24'(clip(s));
    endfunction

    // Track registers, queue predictions, compare each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n) begin
            wave_sel <= WAVE_SAW;
            duty <= PH_FULL / 2;
            phase = 0;
            tri_acc = 0;
            sample_q.delete();
            fail_count <= 0;
            samples_owed <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WAVEFORM)
                    wave_sel <= wave_t'(cfg_data[1:0]);
                else if (cfg_index == CFG_PULSE_WIDTH)
                    duty <= (cfg_data < PW_LO) ? PW_LO : (cfg_data > PW_HI) ? PW_HI : cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                sample_q.push_back(next_sample(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected sample %0d", $signed(m_axis_tdata));
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = sample_q.pop_front();
                    if (want !== m_axis_tdata) begin
                        if (fail_count < 10)
                            $display("sample mismatch: expected %0d, got %0d",
                                $signed(want), $signed(m_axis_tdata));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            samples_owed <= sample_q.size();
        end
    end
endmodule

// File: tb/sv/polyblep_oscillator_unit_tb.sv
// Testbench top of the PolyBLEP oscillator: clock, reset, stimulus and verdict.
module polyblep_oscillator_unit_tb
    import pbo_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [23:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata;   // phase_increment
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;   // sample_value
    int fail_count;
    int samples_owed;
    int sink_hold;

    polyblep_oscillator_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    polyblep_oscillator_unit_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .samples_owed(samples_owed)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // Random increments weighted toward audio-like small values
    function automatic logic [23:0] rand_incr();
        case ($urandom_range(0, 9))
            0, 1: return 24'($urandom);
            2: return 24'($urandom_range(8388000, 8389200));
            3: return 24'($urandom_range(0, 3));
            4, 5, 6: return 24'($urandom_range(1, 20000));
            default: return 24'($urandom_range(20000, 1000000));
        endcase
    endfunction

    // Receiver: random stalls, plus an imposed long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else if (gap_len() > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_incr(logic [23:0] incr);
        int g;
        @(negedge clk);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= incr;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every sample has come and the block is quiet
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (samples_owed != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [23:0] edge_incr [6];
        logic [23:0] pw;
        edge_incr = '{24'd0, 24'd1, 24'd8388608, 24'd8388609, 24'hFFFFFF, 24'd30000};
        sink_hold = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WAVEFORM;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: saw, square and sine at the increment extremes, triangle at one half, pulse width clamps
        foreach (edge_incr[i])
            send_incr(edge_incr[i]);
        drain();
        write_reg(CFG_PULSE_WIDTH, 24'd0);
        write_reg(CFG_WAVEFORM, WAVE_SQUARE);
        foreach (edge_incr[i])
            send_incr(edge_incr[i]);
        drain();
        write_reg(CFG_PULSE_WIDTH, 24'hFFFFFF);
        write_reg(CFG_WAVEFORM, WAVE_TRIANGLE);
        repeat (6) send_incr(24'd8388608);
        drain();
        write_reg(CFG_WAVEFORM, WAVE_SINE);
        foreach (edge_incr[i])
            send_incr(edge_incr[i]);
        drain();

        // Random phases with fresh settings each time
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: pw = 24'd167772;
                1: pw = 24'd16609443;
                default: pw = 24'($urandom);
            endcase
            write_reg(CFG_PULSE_WIDTH, pw);
            write_reg(CFG_WAVEFORM, wave_t'(ph % 4));
            for (int n = 0; n < 172; n++) begin
                if (ph == 2 && n == 40)
                    sink_hold = 600;
                if (ph == 5 && n == 90)
                    drain();
                send_incr(rand_incr());
            end
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
